>>> src/point_in_polygon_test_core_macros.svh
// Assertion macros for the polygon test core.
`ifndef POINT_IN_POLYGON_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_TEST_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PIP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pip: assertion failed");
// condition must never be seen out of reset
`define PIP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `PIP_ASSERT(lbl, clk, rstn, !(cond))
`else
`define PIP_ASSERT(lbl, clk, rstn, prop)
`define PIP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> src/pip_pkg.sv
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic signed [2*COORD_BITS+1:0] prod_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  // query word as it walks the cell row
  typedef struct packed {
    coord_t            px;
    coord_t            py;
    coord_t            v0x;       // first active vertex
    coord_t            v0y;
    coord_t            pvx;       // previous active vertex
    coord_t            pvy;
    logic              have_prev;
    logic [CNT_W-1:0]  cnt;       // active vertices still ahead
    logic              parity;
  } pip_tok_t;

  // sign-extended difference a - b
  function automatic diff_t sub_ext(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = diff_t'(a);
    eb = diff_t'(b);
    return ea - eb;
  endfunction

  // exact crossing test of edge (i, j) against a ray going right from p
  function automatic logic edge_flip(coord_t xi, coord_t yi, coord_t xj, coord_t yj,
                                     coord_t px, coord_t py);
    logic  strad;
    diff_t dy;
    diff_t dxp;
    diff_t dxe;
    diff_t dyp;
    prod_t lhs;
    prod_t rhs;
    logic  left;
    strad = (yi > py) != (yj > py);
    dy    = sub_ext(yj, yi);
    dxp   = sub_ext(px, xi);
    dxe   = sub_ext(xj, xi);
    dyp   = sub_ext(py, yi);
    lhs   = prod_t'(dxp) * prod_t'(dy);
    rhs   = prod_t'(dxe) * prod_t'(dyp);
    left  = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
    return strad && left;
  endfunction

endpackage

>>> src/pip_intf.sv
// input channel: vertex loads and point queries
interface pip_in_if import pip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] vertex_index;
  coord_t           coord_x;
  coord_t           coord_y;

  modport source (output valid, func, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, func, vertex_index, coord_x, coord_y, output ready);
endinterface

// result channel
interface pip_out_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// vertex count register write channel
interface pip_cfg_if import pip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

>>> src/pip_cell.sv
// One vertex slot of the row; evaluates the edge to the previous active vertex.
module pip_cell import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     we_i,
  input  coord_t   wr_x_i,
  input  coord_t   wr_y_i,
  input  logic     vld_i,
  input  pip_tok_t tok_i,
  output logic     vld_o,
  output pip_tok_t tok_o
);

  coord_t   vx_q, vy_q;
  logic     vld_q;
  pip_tok_t tok_q, tok_d;
  logic     active;
  logic     flip;

  // vertex storage
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  // update of the passing word
  always_comb begin
    active = tok_i.cnt != '0;
    flip   = active && tok_i.have_prev &&
             edge_flip(vx_q, vy_q, tok_i.pvx, tok_i.pvy, tok_i.px, tok_i.py);
    tok_d  = tok_i;
    if (active) begin
      tok_d.cnt       = tok_i.cnt - CNT_W'(1);
      tok_d.pvx       = vx_q;
      tok_d.pvy       = vy_q;
      tok_d.have_prev = 1'b1;
      if (!tok_i.have_prev) begin
        tok_d.v0x = vx_q;
        tok_d.v0y = vy_q;
      end
    end
    tok_d.parity = tok_i.parity ^ flip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

>>> src/point_in_polygon_test_core.sv
// Channel  Dir  Payload                                    Word accepted when
// in_i     in   func, vertex_index, coord_x, coord_y       valid && ready
// out_o    out  inside_res                                 valid && ready
// cfg_i    in   vertex_count                               valid && ready (ready tied high)
//
// Loads are taken back to back while no query is in flight.
// A query walks the row of MAX_VERTICES cells, one cell per cycle while the row is not
// stalled, then the closing edge is tested into the output register; the in-flight flag
// clears as the result is registered, and no new word is taken before that.
// A full output register stalls the whole row. Reset clears control and vertex count;
// the vertex store is not cleared.
`include "point_in_polygon_test_core_macros.svh"

module point_in_polygon_test_core import pip_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pip_in_if.sink    in_i,
  pip_out_if.source out_o,
  pip_cfg_if.sink   cfg_i
);

  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                out_vld_q;
  logic                out_res_q;
  logic                in_acc;
  logic                query_acc;
  logic                load_acc;
  logic                adv;
  logic                close_flip;
  logic [MAX_VERTICES:0] vld;
  pip_tok_t            tok [MAX_VERTICES+1];
  pip_tok_t            last_tok;

  assign in_acc    = in_i.valid && in_i.ready;
  assign query_acc = in_acc && (in_i.func == FUNC_QUERY);
  assign load_acc  = in_acc && (in_i.func == FUNC_LOAD);
  assign in_i.ready  = !busy_q;
  assign cfg_i.ready = 1'b1;

  // vertex count register, saturated on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.vertex_count > CNT_W'(MAX_VERTICES)) begin
        cnt_q <= CNT_W'(MAX_VERTICES);
      end else begin
        cnt_q <= cfg_i.vertex_count;
      end
    end
  end

  // word entering the row
  assign vld[0] = query_acc;
  always_comb begin
    tok[0]           = '0;
    tok[0].px        = in_i.coord_x;
    tok[0].py        = in_i.coord_y;
    tok[0].cnt       = cnt_q;
    tok[0].have_prev = 1'b0;
    tok[0].parity    = 1'b0;
  end

  // the row only halts when its result cannot leave
  assign adv = !(vld[MAX_VERTICES] && out_vld_q && !out_o.ready);

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic we;
    assign we = load_acc && (in_i.vertex_index == IDX_W'(k));
    pip_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .we_i   (we),
      .wr_x_i (in_i.coord_x),
      .wr_y_i (in_i.coord_y),
      .vld_i  (vld[k]),
      .tok_i  (tok[k]),
      .vld_o  (vld[k+1]),
      .tok_o  (tok[k+1])
    );
  end

  // closing edge: vertex 0 against the last active vertex
  assign last_tok   = tok[MAX_VERTICES];
  assign close_flip = last_tok.have_prev &&
                      edge_flip(last_tok.v0x, last_tok.v0y, last_tok.pvx, last_tok.pvy,
                                last_tok.px, last_tok.py);

  // output register and in-flight flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (vld[MAX_VERTICES] && adv) begin
        out_vld_q <= 1'b1;
        busy_q    <= 1'b0;
      end else begin
        if (out_o.ready) begin
          out_vld_q <= 1'b0;
        end
        if (query_acc) begin
          busy_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[MAX_VERTICES] && adv) begin
      out_res_q <= last_tok.parity ^ close_flip;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.inside_res = out_res_q;

  `PIP_ASSERT(a_one_query, clk_i, rst_ni, $onehot0(vld))
  `PIP_ASSERT_NEVER(a_ready_empty, clk_i, rst_ni, in_i.ready && (vld[MAX_VERTICES:1] != '0))
  `PIP_ASSERT(a_busy_set, clk_i, rst_ni, query_acc |=> busy_q)
  `PIP_ASSERT(a_stall_hold, clk_i, rst_ni, !adv |=> vld[MAX_VERTICES])

endmodule

>>> verif/point_in_polygon_test_core_test.sv
`timescale 1ns / 1ps

module point_in_polygon_test_core_test;
  import pip_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int TARGET_WORDS  = 1130;
  localparam int IDLE_PCT      = 11;

  // how coordinates of one phase are spread
  typedef enum int {
    SPREAD_FULL,
    SPREAD_WINDOW,
    SPREAD_GRID
  } spread_e;

  // Mirrors the vertex store and count; predicts the even-odd verdict per query
  class polygon_tracker;
    coord_t vx [MAX_VERTICES];
    coord_t vy [MAX_VERTICES];
    int unsigned vcount;
    logic verdicts_due [$];
    int errors;

    function new();
      vcount = 0;
      errors = 0;
      foreach (vx[k]) begin
        vx[k] = '0;
        vy[k] = '0;
      end
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      vcount = v;
    endfunction

    // exact ray crossing walk; 17b x 17b products fit easily in 64 bits
    function logic crossing_parity(coord_t px, coord_t py);
      int n;
      int j;
      logic par;
      longint signed xi, yi, xj, yj, qx, qy, d, lhs, rhs;
      logic left;
      n = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
      par = 1'b0;
      if (n == 0) return 1'b0;
      qx = longint'(px);
      qy = longint'(py);
      j = n - 1;
      for (int i = 0; i < n; i++) begin
        xi = longint'(vx[i]);
        yi = longint'(vy[i]);
        xj = longint'(vx[j]);
        yj = longint'(vy[j]);
        if ((yi > qy) != (yj > qy)) begin
          d = yj - yi;
          lhs = (qx - xi) * d;
          rhs = (xj - xi) * (qy - yi);
          left = (d > 0) ? (lhs < rhs) : (rhs < lhs);
          if (left) par = !par;
        end
        j = i;
      end
      return par;
    endfunction

    function void note_word(func_e f, logic [IDX_W-1:0] idx, coord_t x, coord_t y);
      if (f == FUNC_LOAD) begin
        vx[idx] = x;
        vy[idx] = y;
      end else begin
        verdicts_due.insert(verdicts_due.size(), crossing_parity(x, y));
      end
    endfunction

    function void check_result(logic got);
      logic want;
      if (verdicts_due.size() == 0) begin
        $error("inside_res: result with no query pending, actual %0b", got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $error("inside_res mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit calm;
  int words_sent;
  polygon_tracker sb = new();

  pip_in_if  in_if ();
  pip_out_if out_if ();
  pip_cfg_if cfg_if ();

  point_in_polygon_test_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // saturate to the coordinate range
  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_coord(spread_e mode, int base, int span);
    case (mode)
      SPREAD_WINDOW: return clamp_coord(base + int'($urandom_range(0, 2 * span)) - span);
      SPREAD_GRID: return clamp_coord(base + span * (int'($urandom_range(0, 8)) - 4));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // send one word on the input channel, with random gaps ahead of it
  task automatic push_word(func_e f, logic [IDX_W-1:0] idx, coord_t x, coord_t y);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.vertex_index <= idx;
    in_if.coord_x      <= x;
    in_if.coord_y      <= y;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_word(f, idx, x, y);
    words_sent++;
  endtask

  task automatic load_vertex(int idx, coord_t x, coord_t y);
    push_word(FUNC_LOAD, IDX_W'(idx), x, y);
  endtask

  // index field is don't care on a query
  task automatic query_point(coord_t x, coord_t y);
    push_word(FUNC_QUERY, IDX_W'($urandom), x, y);
  endtask

  // hold the sender until every verdict is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // drain, let any trailing load finish, then write the count register
  task automatic write_count(logic [CNT_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.vertex_count <= v;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    sb.set_count(v);
    cfg_if.valid <= 1'b0;
  endtask

  // one random phase: new count, fresh polygon, then queries mixed with stray loads
  task automatic run_phase(int phase_no);
    int r;
    int cnt;
    int nv;
    int nq;
    int k;
    int base_x;
    int base_y;
    int span;
    spread_e mode;
    coord_t qx;
    coord_t qy;
    r = $urandom_range(0, 99);
    if (r < 5) cnt = 0;
    else if (r < 12) cnt = $urandom_range(1, 2);
    else if (r < 80) cnt = $urandom_range(3, 12);
    else if (r < 90) cnt = MAX_VERTICES;
    else cnt = $urandom_range(MAX_VERTICES + 1, 127);
    write_count(CNT_W'(cnt));
    nv = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;

    r = $urandom_range(0, 9);
    mode = (r < 2) ? SPREAD_FULL : (r < 6) ? SPREAD_WINDOW : SPREAD_GRID;
    base_x = int'($urandom_range(0, 32000)) - 16000;
    base_y = int'($urandom_range(0, 32000)) - 16000;
    span = (mode == SPREAD_GRID) ? $urandom_range(1, 2048) : $urandom_range(1, 4096);

    for (int v = 0; v < nv; v++)
      load_vertex(v, pick_coord(mode, base_x, span), pick_coord(mode, base_y, span));

    nq = $urandom_range(4, 16);
    for (int q = 0; q < nq; q++) begin
      // in phase 2, pause once mid phase until all verdicts are back
      if (phase_no == 2 && q == nq / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        load_vertex($urandom_range(0, MAX_VERTICES - 1),
                    pick_coord(mode, base_x, span), pick_coord(mode, base_y, span));
      end else begin
        qx = pick_coord(mode, base_x, span);
        qy = pick_coord(mode, base_y, span);
        if (r < 30 && nv > 0) begin
          // land on a vertex's y, sometimes exactly on the vertex
          k = $urandom_range(0, nv - 1);
          qy = sb.vy[k];
          if (r < 18) qx = sb.vx[k];
        end else if (r >= 90) begin
          qx = coord_t'($urandom);
          qy = coord_t'($urandom);
        end
        query_point(qx, qy);
      end
    end
  endtask

  // result side: random back-pressure, check every accepted word
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.inside_res);
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // stop at the cycle limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    int phase_no;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.func          <= FUNC_LOAD;
    in_if.vertex_index  <= '0;
    in_if.coord_x       <= '0;
    in_if.coord_y       <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.vertex_count <= '0;
    words_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty polygon
    write_count(CNT_W'(0));
    query_point(coord_t'(-32768), coord_t'(32767));
    query_point(coord_t'(32767), coord_t'(-32768));

    // full-range triangle; points on vertices, on the flat bottom edge, near slanted edges
    load_vertex(0, coord_t'(-32768), coord_t'(-32768));
    load_vertex(1, coord_t'(32767), coord_t'(-32768));
    load_vertex(2, coord_t'(0), coord_t'(32767));
    write_count(CNT_W'(3));
    query_point(coord_t'(0), coord_t'(0));
    query_point(coord_t'(-32768), coord_t'(-32768));
    query_point(coord_t'(32767), coord_t'(32767));
    query_point(coord_t'(0), coord_t'(-32768));
    query_point(coord_t'(-1), coord_t'(32767));
    query_point(coord_t'(0), coord_t'(32766));
    query_point(coord_t'(-16384), coord_t'(0));
    query_point(coord_t'(16384), coord_t'(0));

    // one and two vertices
    write_count(CNT_W'(1));
    query_point(coord_t'(-32768), coord_t'(-32768));
    write_count(CNT_W'(2));
    query_point(coord_t'(0), coord_t'(-32768));
    load_vertex(1, coord_t'(32767), coord_t'(32767));
    query_point(coord_t'(0), coord_t'(0));

    // random phases, with one stretch free of idling
    phase_no = 0;
    while (words_sent < TARGET_WORDS) begin
      calm = (words_sent >= 500 && words_sent < 700);
      run_phase(phase_no);
      phase_no++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/pip_pkg.sv
src/pip_intf.sv
src/pip_cell.sv
src/point_in_polygon_test_core.sv
verif/point_in_polygon_test_core_test.sv
